[design/rei_pkg.sv]
package rei_pkg;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_SEMI_MAJOR = 1'b0,
    CFG_SEMI_MINOR = 1'b1
  } cfg_reg_t;

  // limb size of the partial-product multiplier
  localparam int LIMB = 32;

  // cycles from operand to product in rei_mul, set by the first operand width
  function automatic int mul_lat(input int aw);
    return ((aw + LIMB - 1) >> 5) + 4;
  endfunction

endpackage

[design/rei_if.sv]
// ray request channel
interface rei_req_if #(parameter int W = 48);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] height_above;
  logic signed [W-1:0] origin_x;
  logic signed [W-1:0] origin_y;
  logic signed [W-1:0] origin_z;
  logic signed [W-1:0] dir_x;
  logic signed [W-1:0] dir_y;
  logic signed [W-1:0] dir_z;

  modport source (
    output valid, height_above, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    input  ready
  );
  modport sink (
    input  valid, height_above, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    output ready
  );
endinterface

// ground point response channel
interface rei_rsp_if #(parameter int W = 48);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] ground_x;
  logic signed [W-1:0] ground_y;
  logic signed [W-1:0] ground_z;
  logic                ray_missed;
  logic                degenerate;

  modport source (
    output valid, ground_x, ground_y, ground_z, ray_missed, degenerate,
    input  ready
  );
  modport sink (
    input  valid, ground_x, ground_y, ground_z, ray_missed, degenerate,
    output ready
  );
endinterface

[design/rei_mul.sv]
module rei_mul #(
  parameter int AW = 49,
  parameter int BW = 49
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int L    = rei_pkg::LIMB;
  localparam int NA   = (AW + L - 1) / L;
  localparam int NB   = (BW + L - 1) / L;
  localparam int LA   = NA * L;
  localparam int LB   = NB * L;
  localparam int NS   = NA + 2;
  localparam int RW   = LB + L;
  localparam int SUMW = LA + LB;

  logic [LA-1:0]    ma  [0:NS];
  logic [LB-1:0]    mb  [0:NS];
  logic             ng  [0:NS];
  logic [2*L-1:0]   pp  [1:NS][NB];
  logic [RW-1:0]    row [1:NS];
  logic [SUMW-1:0]  acc [1:NS];

  // magnitudes and product sign
  always_ff @(posedge clk) begin
    if (en) begin
      ma[0] <= LA'($unsigned(a[AW-1] ? -a : a));
      mb[0] <= LB'($unsigned(b[BW-1] ? -b : b));
      ng[0] <= a[AW-1] ^ b[BW-1];
    end
  end

  // one row of limb products per stage, rows combined and accumulated behind it
  for (genvar k = 1; k <= NS; k++) begin : gen_stage
    always_ff @(posedge clk) begin
      if (en) begin
        ma[k] <= ma[k-1];
        mb[k] <= mb[k-1];
        ng[k] <= ng[k-1];
      end
    end

    if (k <= NA) begin : gen_pp
      always_ff @(posedge clk) begin
        if (en) begin
          for (int j = 0; j < NB; j++) begin
            pp[k][j] <= ma[k-1][L*(k-1) +: L] * mb[k-1][L*j +: L];
          end
        end
      end
    end else begin : gen_pp_none
      always_ff @(posedge clk) begin
        if (en) begin
          for (int j = 0; j < NB; j++) begin
            pp[k][j] <= '0;
          end
        end
      end
    end

    if (k >= 2) begin : gen_row
      logic [RW-1:0] ev;
      logic [RW-1:0] od;
      // even and odd limb products do not overlap among themselves
      always_comb begin
        ev = '0;
        od = '0;
        for (int j = 0; j < NB; j++) begin
          if (j % 2 == 0) begin
            ev[L*j +: 2*L] = pp[k-1][j];
          end else begin
            od[L*j +: 2*L] = pp[k-1][j];
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          row[k] <= ev + od;
        end
      end
    end else begin : gen_row_none
      always_ff @(posedge clk) begin
        if (en) begin
          row[k] <= '0;
        end
      end
    end

    if (k >= 3) begin : gen_acc
      always_ff @(posedge clk) begin
        if (en) begin
          acc[k] <= acc[k-1] + (SUMW'(row[k-1]) << (L * (k - 3)));
        end
      end
    end else begin : gen_acc_none
      always_ff @(posedge clk) begin
        if (en) begin
          acc[k] <= '0;
        end
      end
    end
  end

  // restore sign
  always_ff @(posedge clk) begin
    if (en) begin
      p <= ng[NS] ? (AW+BW)'(-acc[NS]) : (AW+BW)'(acc[NS]);
    end
  end

endmodule

[design/ray_ellipsoid_intersect_top.sv]
// Ray / expanded spheroid intersection.
// Configure semi_major_axis (index 0) and semi_minor_axis (index 1) through
// cfg_we / cfg_index / cfg_data while no ray is in flight. Rays enter on req
// (valid/ready); each accepted transaction yields exactly one transaction on
// rsp with the near ground point, a miss flag and a degenerate flag, in order.
// Throughput: one ray per cycle while the output buffer is not full. A ray
// passes multiplier groups 1 to 3, the square root (one root bit per stage),
// multiplier group 4 and the restoring divider (one quotient bit per stage).
// The pipeline is frozen as a whole while the two-entry output buffer is
// full, so a stalled receiver loses nothing; req.ready comes from a register
// only and stays high while one finished result waits.
// Reset (rst, synchronous) empties the pipeline and buffer and clears both
// axis registers to zero.
module ray_ellipsoid_intersect_top #(
  parameter int COORD_WIDTH = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [COORD_WIDTH-2:0] cfg_data,
  rei_req_if.sink                req,
  rei_rsp_if.source              rsp
);

  localparam int W    = COORD_WIDTH;
  localparam int AW   = W + 1;
  localparam int X1   = 2 * AW;
  localparam int X2   = X1 + 1;
  localparam int PW   = 2 * X2 + 2;
  localparam int DW   = 2 * PW + 1;
  localparam int SW   = PW;
  localparam int UW   = 2 * SW;
  localparam int MW   = PW + 2;
  localparam int NW   = W + MW;
  localparam int NUMW = NW + 1;
  localparam int GW   = NUMW + 2;

  localparam int L1 = rei_pkg::mul_lat(AW);
  localparam int L2 = rei_pkg::mul_lat(X2);
  localparam int L3 = rei_pkg::mul_lat(PW);
  localparam int L4 = rei_pkg::mul_lat(W);

  localparam int S_IN  = 1;
  localparam int S_G1  = S_IN + L1;
  localparam int S_SUM = S_G1 + 1;
  localparam int S_G2  = S_SUM + L2;
  localparam int S_PQR = S_G2 + 1;
  localparam int S_G3  = S_PQR + L3;
  localparam int S_D   = S_G3 + 1;
  localparam int S_SQ  = S_D + SW;
  localparam int S_M   = S_SQ + 1;
  localparam int S_G4  = S_M + L4;
  localparam int S_NUM = S_G4 + 1;
  localparam int S_Q   = S_NUM + NUMW;

  localparam int N_C  = S_Q - S_IN;
  localparam int N_D  = S_M - S_IN;
  localparam int N_P  = S_G4 - S_PQR;
  localparam int N_Q  = S_SQ - S_PQR;
  localparam int N_PZ = S_Q - S_PQR;
  localparam int N_MS = S_Q - S_D;

  // group 1 product slots
  localparam int G1_AA = 0;
  localparam int G1_BB = 1;
  localparam int G1_DD = 2;
  localparam int G1_DC = 5;
  localparam int G1_CC = 8;
  localparam int G1_N  = 11;

  typedef struct packed {
    logic signed [W-1:0] gx;
    logic signed [W-1:0] gy;
    logic signed [W-1:0] gz;
    logic                missed;
    logic                degen;
  } out_t;

  logic [W-2:0] semi_major;
  logic [W-2:0] semi_minor;
  logic         en;
  logic         v [S_IN:S_Q];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      semi_major <= '0;
      semi_minor <= '0;
    end else if (cfg_we) begin
      unique case (rei_pkg::cfg_reg_t'(cfg_index))
        rei_pkg::CFG_SEMI_MAJOR: semi_major <= cfg_data;
        rei_pkg::CFG_SEMI_MINOR: semi_minor <= cfg_data;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = S_IN; i <= S_Q; i++) begin
        v[i] <= 1'b0;
      end
    end else if (en) begin
      v[S_IN] <= req.valid;
      for (int i = S_IN + 1; i <= S_Q; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  assign req.ready = en;

  // input stage: expanded axes
  logic signed [AW-1:0] a1, b1;
  logic signed [W-1:0]  c1 [3];
  logic signed [W-1:0]  d1 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= $signed({2'b00, semi_major}) + AW'(req.height_above);
      b1    <= $signed({2'b00, semi_minor}) + AW'(req.height_above);
      c1[0] <= req.origin_x;
      c1[1] <= req.origin_y;
      c1[2] <= req.origin_z;
      d1[0] <= req.dir_x;
      d1[1] <= req.dir_y;
      d1[2] <= req.dir_z;
    end
  end

  // side delay lines
  logic signed [W-1:0]  c_dl  [N_C][3];
  logic signed [W-1:0]  d_dl  [N_D][3];
  logic signed [PW-1:0] p_dl  [N_P];
  logic signed [PW-1:0] q_dl  [N_Q];
  logic                 pz_dl [N_PZ];
  logic                 ms_dl [N_MS];
  logic [2:0]           ng_dl [NUMW];

  logic signed [PW-1:0] p_r, q_r, r_r;
  logic                 miss_r;
  logic [2:0]           neg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_dl[0]  <= c1;
      d_dl[0]  <= d1;
      p_dl[0]  <= p_r;
      q_dl[0]  <= q_r;
      pz_dl[0] <= (p_r == '0);
      ms_dl[0] <= miss_r;
      ng_dl[0] <= neg_r;
      for (int i = 1; i < N_C; i++)  c_dl[i]  <= c_dl[i-1];
      for (int i = 1; i < N_D; i++)  d_dl[i]  <= d_dl[i-1];
      for (int i = 1; i < N_P; i++)  p_dl[i]  <= p_dl[i-1];
      for (int i = 1; i < N_Q; i++)  q_dl[i]  <= q_dl[i-1];
      for (int i = 1; i < N_PZ; i++) pz_dl[i] <= pz_dl[i-1];
      for (int i = 1; i < N_MS; i++) ms_dl[i] <= ms_dl[i-1];
      for (int i = 1; i < NUMW; i++) ng_dl[i] <= ng_dl[i-1];
    end
  end

  // group 1: squares and cross terms of axes, origin and direction
  logic signed [AW-1:0] g1a [G1_N];
  logic signed [AW-1:0] g1b [G1_N];
  logic signed [X1-1:0] g1p [G1_N];

  always_comb begin
    g1a[G1_AA] = a1;
    g1b[G1_AA] = a1;
    g1a[G1_BB] = b1;
    g1b[G1_BB] = b1;
    for (int i = 0; i < 3; i++) begin
      g1a[G1_DD+i] = AW'(d1[i]);
      g1b[G1_DD+i] = AW'(d1[i]);
      g1a[G1_DC+i] = AW'(d1[i]);
      g1b[G1_DC+i] = AW'(c1[i]);
      g1a[G1_CC+i] = AW'(c1[i]);
      g1b[G1_CC+i] = AW'(c1[i]);
    end
  end

  for (genvar i = 0; i < G1_N; i++) begin : gen_g1
    rei_mul #(.AW(AW), .BW(AW)) u_mul (
      .clk(clk), .en(en), .a(g1a[i]), .b(g1b[i]), .p(g1p[i])
    );
  end

  // equatorial sums
  logic signed [X2-1:0] sa2, sb2, sdd, sdz, sdc, sdcz, scc, scz;

  always_ff @(posedge clk) begin
    if (en) begin
      sa2  <= X2'(g1p[G1_AA]);
      sb2  <= X2'(g1p[G1_BB]);
      sdd  <= X2'(g1p[G1_DD]) + X2'(g1p[G1_DD+1]);
      sdz  <= X2'(g1p[G1_DD+2]);
      sdc  <= X2'(g1p[G1_DC]) + X2'(g1p[G1_DC+1]);
      sdcz <= X2'(g1p[G1_DC+2]);
      scc  <= X2'(g1p[G1_CC]) + X2'(g1p[G1_CC+1]);
      scz  <= X2'(g1p[G1_CC+2]);
    end
  end

  // group 2: axis-weighted terms
  logic signed [X2-1:0]   g2a [7];
  logic signed [X2-1:0]   g2b [7];
  logic signed [2*X2-1:0] g2p [7];

  always_comb begin
    g2a[0] = sb2; g2b[0] = sdd;
    g2a[1] = sa2; g2b[1] = sdz;
    g2a[2] = sb2; g2b[2] = sdc;
    g2a[3] = sa2; g2b[3] = sdcz;
    g2a[4] = sb2; g2b[4] = scc;
    g2a[5] = sa2; g2b[5] = scz;
    g2a[6] = sa2; g2b[6] = sb2;
  end

  for (genvar i = 0; i < 7; i++) begin : gen_g2
    rei_mul #(.AW(X2), .BW(X2)) u_mul (
      .clk(clk), .en(en), .a(g2a[i]), .b(g2b[i]), .p(g2p[i])
    );
  end

  // quadratic coefficients
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= PW'(g2p[0]) + PW'(g2p[1]);
      q_r <= PW'(g2p[2]) + PW'(g2p[3]);
      r_r <= PW'(g2p[4]) + PW'(g2p[5]) - PW'(g2p[6]);
    end
  end

  // group 3: discriminant terms
  logic signed [2*PW-1:0] qq_p, pr_p;

  rei_mul #(.AW(PW), .BW(PW)) u_mul_qq (
    .clk(clk), .en(en), .a(q_r), .b(q_r), .p(qq_p)
  );
  rei_mul #(.AW(PW), .BW(PW)) u_mul_pr (
    .clk(clk), .en(en), .a(p_r), .b(r_r), .p(pr_p)
  );

  // discriminant, clamped at zero on a miss
  logic signed [DW-1:0] disc;
  logic [SW:0]          sq_rem  [0:SW];
  logic [SW-1:0]        sq_root [0:SW];
  logic [UW-1:0]        sq_rad  [0:SW];

  assign disc = DW'(qq_p) - DW'(pr_p);

  always_ff @(posedge clk) begin
    if (en) begin
      miss_r     <= disc[DW-1];
      sq_rad[0]  <= disc[DW-1] ? '0 : disc[UW-1:0];
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  // square root, one root bit per stage
  for (genvar k = 1; k <= SW; k++) begin : gen_sqrt
    logic [SW+2:0] cur;
    logic [SW+2:0] trial;
    logic          ge;

    always_comb begin
      cur   = {sq_rem[k-1], sq_rad[k-1][UW-1 -: 2]};
      trial = (SW+3)'({sq_root[k-1], 2'b01});
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[k]  <= ge ? (SW+1)'(cur - trial) : cur[SW:0];
        sq_root[k] <= {sq_root[k-1][SW-2:0], ge};
        sq_rad[k]  <= {sq_rad[k-1][UW-3:0], 2'b00};
      end
    end
  end

  // near root numerator
  logic signed [MW-1:0] m_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= -(MW'(q_dl[N_Q-1]) + MW'(sq_root[SW]));
    end
  end

  // group 4: direction times numerator
  logic signed [NW-1:0] n_p [3];

  for (genvar i = 0; i < 3; i++) begin : gen_g4
    rei_mul #(.AW(W), .BW(MW)) u_mul (
      .clk(clk), .en(en), .a(d_dl[N_D-1][i]), .b(m_r), .p(n_p[i])
    );
  end

  // rounded division setup: (2|N| + P) / 2P
  logic [NUMW-1:0] dv_nq  [3][0:NUMW];
  logic [PW-1:0]   dv_rem [3][0:NUMW];
  logic [PW-1:0]   dv_den [0:NUMW];

  for (genvar i = 0; i < 3; i++) begin : gen_num
    logic [NW-1:0] mag;

    assign mag = NW'($unsigned(n_p[i][NW-1] ? -n_p[i] : n_p[i]));

    always_ff @(posedge clk) begin
      if (en) begin
        dv_nq[i][0]  <= {mag, 1'b0} + NUMW'(p_dl[N_P-1][PW-2:0]);
        dv_rem[i][0] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= n_p[i][NW-1];
      end
      dv_den[0] <= {p_dl[N_P-1][PW-2:0], 1'b0};
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 1; k <= NUMW; k++) begin : gen_div
    always_ff @(posedge clk) begin
      if (en) begin
        dv_den[k] <= dv_den[k-1];
      end
    end

    for (genvar i = 0; i < 3; i++) begin : gen_lane
      logic [PW:0] cur;
      logic        ge;

      always_comb begin
        cur = {dv_rem[i][k-1], dv_nq[i][k-1][NUMW-1]};
        ge  = (cur >= {1'b0, dv_den[k-1]});
      end

      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem[i][k] <= ge ? PW'(cur - {1'b0, dv_den[k-1]}) : cur[PW-1:0];
          dv_nq[i][k]  <= {dv_nq[i][k-1][NUMW-2:0], ge};
        end
      end
    end
  end

  // ground point with saturation, degenerate rays return the origin
  logic signed [W-1:0] gnd [3];

  for (genvar i = 0; i < 3; i++) begin : gen_gnd
    logic signed [GW-1:0] qs;
    logic signed [GW-1:0] g;
    logic                 fits;

    always_comb begin
      qs   = ng_dl[NUMW-1][i] ? -GW'(dv_nq[i][NUMW]) : GW'(dv_nq[i][NUMW]);
      g    = GW'(c_dl[N_C-1][i]) + qs;
      fits = (&g[GW-1:W-1]) || !(|g[GW-1:W-1]);
      if (pz_dl[N_PZ-1]) begin
        gnd[i] = c_dl[N_C-1][i];
      end else if (fits) begin
        gnd[i] = g[W-1:0];
      end else begin
        gnd[i] = g[GW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  // two-entry output buffer
  out_t       ob0, ob1, res;
  logic [1:0] cnt;
  logic [1:0] pos;
  logic       push, pop;

  always_comb begin
    res.gx     = gnd[0];
    res.gy     = gnd[1];
    res.gz     = gnd[2];
    res.missed = ms_dl[N_MS-1] && !pz_dl[N_PZ-1];
    res.degen  = pz_dl[N_PZ-1];
    en         = (cnt != 2'd2);
    push       = en && v[S_Q];
    pop        = rsp.valid && rsp.ready;
    pos        = cnt - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ob0 <= ob1;
    end
    if (push) begin
      if (pos == 2'd0) begin
        ob0 <= res;
      end else begin
        ob1 <= res;
      end
    end
  end

  assign rsp.valid      = (cnt != 2'd0);
  assign rsp.ground_x   = ob0.gx;
  assign rsp.ground_y   = ob0.gy;
  assign rsp.ground_z   = ob0.gz;
  assign rsp.ray_missed = ob0.missed;
  assign rsp.degenerate = ob0.degen;

endmodule

[bench/ray_ground_checker.sv]
`timescale 1ns / 1ps

module ray_ground_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [46:0] cfg_data,
  rei_req_if          req,
  rei_rsp_if          rsp,
  output int          fails,
  output int          pending
);

  // wide enough for every exact intermediate of the quadratic
  typedef logic signed [447:0] wide_t;

  typedef struct {
    logic signed [47:0] gx;
    logic signed [47:0] gy;
    logic signed [47:0] gz;
    logic               missed;
    logic               degen;
  } ground_t;

  logic [46:0] major_axis;
  logic [46:0] minor_axis;
  ground_t     ground_queue[$];

  // floor square root of a non-negative wide value
  function automatic wide_t floor_sqrt(input wide_t x);
    logic [447:0] rem;
    logic [447:0] root;
    logic [447:0] bitv;
    int k;
    rem  = x;
    root = '0;
    bitv = 448'd1 << 446;
    for (k = 0; k < 224; k++) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return wide_t'(root);
  endfunction

  // near ground point of the ray on the height-expanded spheroid
  function automatic ground_t predict_ground(
    input logic signed [47:0] h_in,
    input logic signed [47:0] ox, input logic signed [47:0] oy, input logic signed [47:0] oz,
    input logic signed [47:0] vx, input logic signed [47:0] vy, input logic signed [47:0] vz,
    input logic [46:0] amaj, input logic [46:0] amin);
    ground_t res;
    wide_t h, ax, bx, a2, b2, p, q, r, disc, s, m, n, num, quo, g, lo, hi;
    wide_t c[3];
    wide_t d[3];
    logic neg;
    int i;
    h    = h_in;
    c[0] = ox; c[1] = oy; c[2] = oz;
    d[0] = vx; d[1] = vy; d[2] = vz;
    ax = $signed({401'b0, amaj}) + h;
    bx = $signed({401'b0, amin}) + h;
    a2 = ax * ax;
    b2 = bx * bx;
    p = b2 * (d[0] * d[0] + d[1] * d[1]) + a2 * (d[2] * d[2]);
    q = b2 * (d[0] * c[0] + d[1] * c[1]) + a2 * (d[2] * c[2]);
    r = b2 * (c[0] * c[0] + c[1] * c[1]) + a2 * (c[2] * c[2]) - a2 * b2;
    res.missed = 1'b0;
    res.degen  = 1'b0;
    if (p == 0) begin
      res.gx = ox; res.gy = oy; res.gz = oz;
      res.degen = 1'b1;
      return res;
    end
    disc = q * q - p * r;
    if (disc < 0) begin
      disc = 0;
      res.missed = 1'b1;
    end
    s  = floor_sqrt(disc);
    m  = -(q + s);
    hi = (wide_t'(1) <<< 47) - 1;
    lo = -(wide_t'(1) <<< 47);
    for (i = 0; i < 3; i++) begin
      // t*d rounded to nearest, ties away from zero
      n   = d[i] * m;
      neg = n < 0;
      if (neg) n = -n;
      num = n + n + p;
      quo = num / (p + p);
      if (neg) quo = -quo;
      g = c[i] + quo;
      if (g < lo) g = lo;
      else if (g > hi) g = hi;
      if (i == 0) res.gx = g[47:0];
      else if (i == 1) res.gy = g[47:0];
      else res.gz = g[47:0];
    end
    return res;
  endfunction

  // mirror config, predict on request, compare on response
  always @(posedge clk) begin
    ground_t want;
    if (rst) begin
      major_axis <= '0;
      minor_axis <= '0;
      ground_queue.delete();
      fails   = 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rei_pkg::CFG_SEMI_MAJOR) major_axis <= cfg_data;
        else minor_axis <= cfg_data;
      end
      if (rsp.valid && rsp.ready) begin
        if (ground_queue.size() == 0) begin
          $display("%0t: unexpected result transaction x=%0d", $time, rsp.ground_x);
          fails++;
        end else begin
          want = ground_queue.pop_front();
          if (rsp.ground_x !== want.gx) begin
            $display("%0t: ground_x exp %0d got %0d", $time, want.gx, rsp.ground_x);
            fails++;
          end
          if (rsp.ground_y !== want.gy) begin
            $display("%0t: ground_y exp %0d got %0d", $time, want.gy, rsp.ground_y);
            fails++;
          end
          if (rsp.ground_z !== want.gz) begin
            $display("%0t: ground_z exp %0d got %0d", $time, want.gz, rsp.ground_z);
            fails++;
          end
          if (rsp.ray_missed !== want.missed) begin
            $display("%0t: ray_missed exp %0b got %0b", $time, want.missed, rsp.ray_missed);
            fails++;
          end
          if (rsp.degenerate !== want.degen) begin
            $display("%0t: degenerate exp %0b got %0b", $time, want.degen, rsp.degenerate);
            fails++;
          end
        end
      end
      if (req.valid && req.ready)
        ground_queue.push_back(predict_ground(req.height_above, req.origin_x, req.origin_y,
          req.origin_z, req.dir_x, req.dir_y, req.dir_z, major_axis, minor_axis));
      pending <= ground_queue.size();
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam logic [46:0] AXIS_MAX = {47{1'b1}};

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [46:0] cfg_data;
  logic        tail_phase;
  int          fails;
  int          pending;
  longint      axis_a;
  longint      axis_b;

  rei_req_if #(.W(48)) req ();
  rei_rsp_if #(.W(48)) rsp ();

  ray_ellipsoid_intersect_top #(.COORD_WIDTH(48)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .rsp(rsp)
  );

  ray_ground_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .rsp(rsp), .fails(fails), .pending(pending)
  );

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // run limit
  initial begin
    #4ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  // signed value in [-m, m]
  function automatic longint srange(input longint m);
    longint unsigned u;
    u = {$urandom, $urandom};
    return longint'(u % longint'(2 * m + 1)) - m;
  endfunction

  // receiver stalls in bursts
  initial begin
    rsp.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!tail_phase && $urandom_range(0, 3) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic write_axis(input rei_pkg::cfg_reg_t idx, input logic [46:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one ray transaction, with an optional idle burst first
  task automatic send_ray(input logic [47:0] h, input logic [47:0] ox, input logic [47:0] oy,
                          input logic [47:0] oz, input logic [47:0] vx,
                          input logic [47:0] vy, input logic [47:0] vz);
    if (!tail_phase && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.height_above <= h;
    req.origin_x     <= ox;
    req.origin_y     <= oy;
    req.origin_z     <= oz;
    req.dir_x        <= vx;
    req.dir_y        <= vy;
    req.dir_z        <= vz;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // stop sending and wait for every result
  task automatic drain();
    req.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_axes(input logic [46:0] a, input logic [46:0] b);
    drain();
    write_axis(rei_pkg::CFG_SEMI_MAJOR, a);
    write_axis(rei_pkg::CFG_SEMI_MINOR, b);
    axis_a = (a > 47'd1 << 40) ? (longint'(1) << 40) : ((a == 0) ? 1000 : longint'(a));
    axis_b = longint'(b);
  endtask

  // mostly rays aimed at the body from outside, some noise and odd cases
  task automatic random_rays(input int count);
    longint s, ox, oy, oz, vx, vy, vz, h;
    int sel, k;
    for (k = 0; k < count; k++) begin
      s   = axis_a;
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        ox = srange(2 * s); oy = srange(2 * s); oz = srange(2 * s);
        case ($urandom_range(0, 2))
          0: ox = ox + ((ox < 0) ? -2 * s : 2 * s);
          1: oy = oy + ((oy < 0) ? -2 * s : 2 * s);
          default: oz = oz + ((oz < 0) ? -2 * s : 2 * s);
        endcase
        vx = (-ox + srange(s / 2)) >>> $urandom_range(0, 8);
        vy = (-oy + srange(s / 2)) >>> $urandom_range(0, 8);
        vz = (-oz + srange(s / 2)) >>> $urandom_range(0, 8);
        h  = srange(s / 16);
        send_ray(h[47:0], ox[47:0], oy[47:0], oz[47:0], vx[47:0], vy[47:0], vz[47:0]);
      end else if (sel < 9) begin
        send_ray(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(), rand48());
      end else begin
        h  = ($urandom_range(0, 1) == 1) ? -axis_b : 0;
        vz = ($urandom_range(0, 1) == 1) ? 0 : srange(s);
        vx = ($urandom_range(0, 1) == 1) ? 0 : srange(s);
        send_ray(h[47:0], rand48() >>> 8, rand48() >>> 8, rand48() >>> 8,
                 vx[47:0], 48'd0, vz[47:0]);
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    longint s;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = rei_pkg::CFG_SEMI_MAJOR;
    cfg_data   = '0;
    tail_phase = 1'b0;
    req.valid  = 1'b0;
    req.height_above = '0;
    req.origin_x = '0; req.origin_y = '0; req.origin_z = '0;
    req.dir_x = '0; req.dir_y = '0; req.dir_z = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rays on a mid-size body
    s = longint'(1) << 30;
    set_axes(47'(s), 47'(s - (s >> 6)));
    send_ray(48'd0, 48'(3 * s), 48'd0, 48'd0, 48'(-s), 48'd0, 48'd0);
    send_ray(48'd0, 48'd0, 48'd0, 48'(3 * s), 48'd0, 48'd0, 48'(-s));
    send_ray(48'd0, 48'(3 * s), 48'd0, 48'd0, 48'd0, 48'(s), 48'd0);
    send_ray(48'(s >> 4), 48'(s), 48'(s), 48'(s), 48'd0, 48'd0, 48'd0);
    send_ray({1'b0, {47{1'b1}}}, {1'b0, {47{1'b1}}}, {1'b0, {47{1'b1}}},
             {1'b0, {47{1'b1}}}, {1'b0, {47{1'b1}}}, {1'b0, {47{1'b1}}},
             {1'b0, {47{1'b1}}});
    send_ray({1'b1, 47'd0}, {1'b1, 47'd0}, {1'b1, 47'd0}, {1'b1, 47'd0},
             {1'b1, 47'd0}, {1'b1, 47'd0}, {1'b1, 47'd0});
    send_ray({1'b1, 47'd0}, {1'b0, {47{1'b1}}}, {1'b1, 47'd0}, {1'b0, {47{1'b1}}},
             {1'b1, 47'd0}, {1'b0, {47{1'b1}}}, {1'b1, 47'd0});
    // polar axis collapsed to zero, with and without a vertical component
    send_ray(48'(-(s - (s >> 6))), 48'(s >> 1), 48'd0, 48'(2 * s), 48'd0, 48'd0, 48'(-s));
    send_ray(48'(-(s - (s >> 6))), 48'(s >> 1), 48'd0, 48'(2 * s), 48'(s), 48'd0, 48'd0);
    // equatorial axis collapsed to zero
    send_ray(48'(-s), 48'(s), 48'd0, 48'(s), 48'd0, 48'd0, 48'(-s));
    // results beyond the coordinate range
    send_ray(48'd0, {1'b0, {47{1'b1}}} - 48'd5, 48'd0, 48'd0, 48'(s), 48'd0, 48'd0);
    send_ray(48'd0, {1'b1, 47'd5}, 48'd0, 48'd0, 48'(-s), 48'd0, 48'd0);
    // origin inside, tangent ray, tiny direction
    send_ray(48'd0, 48'd0, 48'd0, 48'd0, 48'(s), 48'(s), 48'd0);
    send_ray(48'd0, 48'(2 * s), 48'(s), 48'd0, 48'(-s), 48'd0, 48'd0);
    send_ray(48'd0, 48'(3 * s), 48'd1, 48'd0, -48'd1, 48'd0, 48'd0);
    send_ray(48'(-s), 48'(-s), 48'(-s), 48'(-s), 48'd1, 48'd1, 48'd1);
    random_rays(280);

    // extreme axes
    set_axes(AXIS_MAX, AXIS_MAX);
    random_rays(150);
    set_axes('0, '0);
    random_rays(100);

    // earth-like body, with a full drain in the middle
    set_axes(47'(longint'(6378137) << 16), 47'(longint'(6356752) << 16));
    random_rays(150);
    drain();
    random_rays(150);

    // flat body
    set_axes(47'({$urandom, $urandom} >> 20), '0);
    random_rays(100);

    // closing stretch with no idling on either side
    set_axes(47'($urandom_range(1000, 1 << 30)), 47'($urandom_range(0, 1 << 30)));
    tail_phase = 1'b1;
    random_rays(250);

    drain();
    repeat (600) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
